@@ rtl/sef_pkg.sv @@
package sef_pkg;

  localparam int unsigned POS_W = 16;
  localparam logic [POS_W-1:0] POS_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_ADD   = 2'd1,
    REQ_TEST  = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic start;
    logic add;
    logic test_load;
    logic rd_en;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic scan_last;
    logic out_free;
  } status_t;

endpackage

@@ rtl/set_exclusion_index_filter.sv @@
// channel | signals                                     | accepted when
// --------+---------------------------------------------+---------------------
// in      | in_valid, in_ready, req_type, element_value | in_valid & in_ready
// out     | out_valid, out_ready, position, kept,        | out_valid & out_ready
//         | set_overflow                                 |
// Start and add items are done in the idle state.
// A test item does load, then one read of the member memory per cycle over
// the stored members, then final compare and result load.
// With an empty set a test item goes from load straight to result load.
// Reset is synchronous and active high; the member memory needs no clearing.
// A waiting result holds only the last step of the next test item.
module set_exclusion_index_filter
  import sef_pkg::*;
#(
  parameter int unsigned SET_SIZE = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         req_type,
  input  logic signed [31:0] element_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        position,
  output logic               kept,
  output logic               set_overflow
);

  cmd_t    cmd;
  status_t status;

  sef_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .req_type (req_type),
    .status   (status),
    .cmd      (cmd)
  );

  sef_dp #(
    .SET_SIZE (SET_SIZE)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .element_value (element_value),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .position      (position),
    .kept          (kept),
    .set_overflow  (set_overflow)
  );

endmodule

@@ rtl/sef_ctrl.sv @@
module sef_ctrl
  import sef_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] req_type,
  input  status_t    status,
  output cmd_t       cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (req_type)
            REQ_START: cmd.start = 1'b1;
            REQ_ADD:   cmd.add = 1'b1;
            REQ_TEST: begin
              cmd.test_load = 1'b1;
              state_next    = status.count_zero ? ST_FIN : ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        cmd.rd_en = 1'b1;
        if (status.scan_last) begin
          state_next = ST_LAST;
        end
      end
      ST_LAST: begin
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

@@ rtl/sef_dp.sv @@
module sef_dp
  import sef_pkg::*;
#(
  parameter int unsigned SET_SIZE = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic signed [31:0] element_value,
  input  cmd_t               cmd,
  output status_t            status,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [POS_W-1:0]   position,
  output logic               kept,
  output logic               set_overflow
);

  localparam int unsigned CW = $clog2(SET_SIZE + 1);
  localparam int unsigned AW = (SET_SIZE > 1) ? $clog2(SET_SIZE) : 1;

  logic [31:0]      mem [SET_SIZE];
  logic [CW-1:0]    count;
  logic [CW-1:0]    idx;
  logic [POS_W-1:0] pos;
  logic             ovf;
  logic [31:0]      test_val;
  logic [31:0]      rd_data;
  logic             rd_valid;
  logic             hit;
  logic             full;

  assign full              = (count == CW'(SET_SIZE));
  assign status.count_zero = (count == '0);
  assign status.scan_last  = ((idx + CW'(1)) == count);
  assign status.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.add && !full) begin
      mem[count[AW-1:0]] <= element_value;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      pos       <= '0;
      ovf       <= 1'b0;
      idx       <= '0;
      rd_valid  <= 1'b0;
      hit       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.rd_en;
      if (cmd.start) begin
        count <= '0;
        pos   <= '0;
        ovf   <= 1'b0;
      end
      if (cmd.add) begin
        if (full) begin
          ovf <= 1'b1;
        end else begin
          count <= count + CW'(1);
        end
      end
      if (cmd.test_load) begin
        idx <= '0;
        hit <= 1'b0;
        if (pos != POS_MAX) begin
          pos <= pos + POS_W'(1);
        end
      end else begin
        if (cmd.rd_en) begin
          idx <= idx + CW'(1);
        end
        if (rd_valid && rd_data == test_val) begin
          hit <= 1'b1;
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.test_load) begin
      test_val <= element_value;
    end
    if (cmd.out_load) begin
      position     <= pos;
      kept         <= !hit;
      set_overflow <= ovf;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result loaded over an untaken item");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |-> (idx < count))
    else $error("scan read beyond stored members");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(SET_SIZE))
    else $error("member count above capacity");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("loaded result not presented");

endmodule
